// ----- rtl/hct_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hct_pkg;

	// scale target for absolute moves
	localparam logic [15:0] SCALE_MAX = 16'd32767;

	localparam logic [15:0] WIDTH_RESET  = 16'd1920;
	localparam logic [15:0] HEIGHT_RESET = 16'd1080;

	// configuration register indexes
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// report kinds
	localparam logic [1:0] KIND_BTN  = 2'd0;
	localparam logic [1:0] KIND_MOVE = 2'd1;
	localparam logic [1:0] KIND_KEY  = 2'd2;

	// command actions
	localparam logic [3:0] ACT_KEY_DOWN   = 4'd0;
	localparam logic [3:0] ACT_KEY_UP     = 4'd1;
	localparam logic [3:0] ACT_KEY_CLICK  = 4'd2;
	localparam logic [3:0] ACT_LEFT_DOWN  = 4'd3;
	localparam logic [3:0] ACT_LEFT_UP    = 4'd4;
	localparam logic [3:0] ACT_LEFT_CLICK = 4'd5;
	localparam logic [3:0] ACT_RGT_DOWN   = 4'd6;
	localparam logic [3:0] ACT_RGT_UP     = 4'd7;
	localparam logic [3:0] ACT_RGT_CLICK  = 4'd8;
	localparam logic [3:0] ACT_MOVE       = 4'd9;

	// host modifier key codes
	localparam logic [7:0] VK_SHIFT = 8'd16;
	localparam logic [7:0] VK_CTRL  = 8'd17;
	localparam logic [7:0] VK_ALT   = 8'd18;

	// microprogram addresses
	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] STEP_IDLE      = 4'd0;
	localparam logic [PC_W-1:0] STEP_MOD_SET   = 4'd1;
	localparam logic [PC_W-1:0] STEP_MOD_CLR   = 4'd2;
	localparam logic [PC_W-1:0] STEP_KEY_UP    = 4'd3;
	localparam logic [PC_W-1:0] STEP_KEY_DOWN  = 4'd4;
	localparam logic [PC_W-1:0] STEP_KEY_CLK_A = 4'd5;
	localparam logic [PC_W-1:0] STEP_KEY_CLK_B = 4'd6;
	localparam logic [PC_W-1:0] STEP_BTN_DOWN  = 4'd7;
	localparam logic [PC_W-1:0] STEP_BTN_UP    = 4'd8;
	localparam logic [PC_W-1:0] STEP_BTN_CLK_A = 4'd9;
	localparam logic [PC_W-1:0] STEP_BTN_CLK_B = 4'd10;
	localparam logic [PC_W-1:0] STEP_MUL       = 4'd11;
	localparam logic [PC_W-1:0] STEP_DIV_INIT  = 4'd12;
	localparam logic [PC_W-1:0] STEP_DIV_LOOP  = 4'd13;
	localparam logic [PC_W-1:0] STEP_MOVE_OUT  = 4'd14;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_MOD_SET,
		OP_MOD_CLR,
		OP_HELD_LOAD,
		OP_HELD_CLR,
		OP_BTN_SET,
		OP_BTN_CLR,
		OP_MUL,
		OP_DIV_INIT,
		OP_DIV_STEP
	} op_t;

	typedef enum logic [1:0] {
		SEQ_WAIT,
		SEQ_NEXT,
		SEQ_LOOP,
		SEQ_END
	} seq_t;

	typedef struct packed {
		op_t        op;
		logic       emit;
		logic [1:0] kind;
		logic       last;
		seq_t       seq;
	} ctrl_word_t;

	function automatic ctrl_word_t cw(input op_t op, input logic emit, input logic [1:0] kind,
		input logic last, input seq_t seq);
		ctrl_word_t w;
		w.op = op;
		w.emit = emit;
		w.kind = kind;
		w.last = last;
		w.seq = seq;
		return w;
	endfunction

	// control store
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		unique case (pc)
			STEP_IDLE:      w = cw(OP_NONE,      1'b0, KIND_BTN,  1'b0, SEQ_WAIT);
			STEP_MOD_SET:   w = cw(OP_MOD_SET,   1'b1, KIND_KEY,  1'b1, SEQ_END);
			STEP_MOD_CLR:   w = cw(OP_MOD_CLR,   1'b1, KIND_KEY,  1'b1, SEQ_END);
			STEP_KEY_UP:    w = cw(OP_HELD_CLR,  1'b1, KIND_KEY,  1'b1, SEQ_END);
			STEP_KEY_DOWN:  w = cw(OP_HELD_LOAD, 1'b1, KIND_KEY,  1'b1, SEQ_END);
			STEP_KEY_CLK_A: w = cw(OP_HELD_LOAD, 1'b1, KIND_KEY,  1'b0, SEQ_NEXT);
			STEP_KEY_CLK_B: w = cw(OP_HELD_CLR,  1'b1, KIND_KEY,  1'b1, SEQ_END);
			STEP_BTN_DOWN:  w = cw(OP_BTN_SET,   1'b1, KIND_BTN,  1'b1, SEQ_END);
			STEP_BTN_UP:    w = cw(OP_BTN_CLR,   1'b1, KIND_BTN,  1'b1, SEQ_END);
			STEP_BTN_CLK_A: w = cw(OP_BTN_SET,   1'b1, KIND_BTN,  1'b0, SEQ_NEXT);
			STEP_BTN_CLK_B: w = cw(OP_BTN_CLR,   1'b1, KIND_BTN,  1'b1, SEQ_END);
			STEP_MUL:       w = cw(OP_MUL,       1'b0, KIND_MOVE, 1'b0, SEQ_NEXT);
			STEP_DIV_INIT:  w = cw(OP_DIV_INIT,  1'b0, KIND_MOVE, 1'b0, SEQ_NEXT);
			STEP_DIV_LOOP:  w = cw(OP_DIV_STEP,  1'b0, KIND_MOVE, 1'b0, SEQ_LOOP);
			STEP_MOVE_OUT:  w = cw(OP_NONE,      1'b1, KIND_MOVE, 1'b1, SEQ_END);
			default:        w = cw(OP_NONE,      1'b0, KIND_BTN,  1'b0, SEQ_END);
		endcase
		return w;
	endfunction

	function automatic logic is_mod_key(input logic [7:0] c);
		return (c == VK_SHIFT) || (c == VK_CTRL) || (c == VK_ALT);
	endfunction

	// entry address per command, idle for commands that do nothing
	function automatic logic [PC_W-1:0] dispatch(input logic [3:0] act, input logic [7:0] c);
		logic [PC_W-1:0] pc;
		unique case (act)
			ACT_KEY_DOWN:   pc = is_mod_key(c) ? STEP_MOD_SET : STEP_KEY_DOWN;
			ACT_KEY_UP:     pc = is_mod_key(c) ? STEP_MOD_CLR : STEP_KEY_UP;
			ACT_KEY_CLICK:  pc = is_mod_key(c) ? STEP_IDLE : STEP_KEY_CLK_A;
			ACT_LEFT_DOWN,
			ACT_RGT_DOWN:   pc = STEP_BTN_DOWN;
			ACT_LEFT_UP,
			ACT_RGT_UP:     pc = STEP_BTN_UP;
			ACT_LEFT_CLICK,
			ACT_RGT_CLICK:  pc = STEP_BTN_CLK_A;
			ACT_MOVE:       pc = STEP_MUL;
			default:        pc = STEP_IDLE;
		endcase
		return pc;
	endfunction

	function automatic logic [2:0] mod_mask(input logic [7:0] c);
		logic [2:0] m;
		priority if (c == VK_CTRL) m = 3'b001;
		else if (c == VK_SHIFT)    m = 3'b010;
		else if (c == VK_ALT)      m = 3'b100;
		else                       m = 3'b000;
		return m;
	endfunction

	// virtual key to hid usage
	function automatic logic [7:0] usage_of(input logic [7:0] c);
		logic [7:0] u;
		priority if (c >= 8'h41 && c <= 8'h5A) u = 8'(8'h04 + (c - 8'h41));
		else if (c >= 8'h31 && c <= 8'h39)     u = 8'(8'h1e + (c - 8'h31));
		else if (c == 8'h30)                   u = 8'h27;
		else if (c >= 8'h70 && c <= 8'h7B)     u = 8'(8'h3a + (c - 8'h70));
		else if (c >= 8'h7C && c <= 8'h87)     u = 8'(8'h68 + (c - 8'h7C));
		else begin
			unique case (c)
				8'd91:   u = 8'h2f;
				8'd92:   u = 8'h31;
				8'd93:   u = 8'h30;
				8'd45:   u = 8'h2d;
				8'd43:   u = 8'h2e;
				8'd44:   u = 8'h36;
				8'd46:   u = 8'h37;
				8'd47:   u = 8'h38;
				8'd13:   u = 8'h28;
				8'd27:   u = 8'h29;
				8'd32:   u = 8'h2c;
				8'd9:    u = 8'h2b;
				default: u = 8'h00;
			endcase
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/hct_cmd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hct_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic [7:0]  key_code;
	logic [15:0] pos_x;
	logic [15:0] pos_y;

	modport source (output valid, action, key_code, pos_x, pos_y, input ready);
	modport sink (input valid, action, key_code, pos_x, pos_y, output ready);
endinterface

`default_nettype wire

// ----- rtl/hct_rpt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hct_rpt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  report_kind;
	logic [1:0]  buttons;
	logic [15:0] abs_x;
	logic [15:0] abs_y;
	logic [2:0]  modifiers;
	logic [7:0]  key_usage;
	logic        last;

	modport source (output valid, report_kind, buttons, abs_x, abs_y, modifiers, key_usage,
		last, input ready);
	modport sink (input valid, report_kind, buttons, abs_x, abs_y, modifiers, key_usage,
		last, output ready);
endinterface

`default_nettype wire

// ----- rtl/hid_command_to_report_translator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   word                                   handshake
// cmd       in    action, key_code, pos_x, pos_y          valid/ready
// rpt       out   kind, buttons, abs_x/y, mods, usage     valid/ready
// cfg       in    cfg_index, cfg_data                     cfg_we, no wait
//
// one command at a time, accepted only while the sequencer sits at its idle step
// key and button commands emit one report word, a click two, a click on a modifier key none
// a move runs multiply, divider setup, 16 restoring divider steps, emit
// an emit step stalls while the output register holds a word not yet taken
// reset clears buttons, modifiers, held usage and loads the default screen extent

module hid_command_to_report_translator_core (
	input  wire         clk,
	input  wire         arst_n,
	hct_cmd_if.sink     cmd,
	hct_rpt_if.source   rpt,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [15:0] cfg_data
);

	logic [hct_pkg::PC_W-1:0] pc_q;
	hct_pkg::ctrl_word_t      cw;

	logic [15:0] width_q, height_q;
	logic [1:0]  btn_q, btn_d;
	logic [2:0]  mod_q, mod_d;
	logic [7:0]  held_q, held_d;

	logic [3:0]  act_q;
	logic [7:0]  code_q;
	logic [15:0] px_q, py_q;

	logic [31:0] prodx_q, prody_q;
	logic [15:0] remx_q, remy_q, lox_q, loy_q;
	logic        satx_q, saty_q;
	logic [3:0]  cnt_q;

	logic        ov_q;
	logic        go;
	logic        accept;
	logic [15:0] dx, dy;
	logic [16:0] tx, ty;
	logic        gex, gey;
	logic [1:0]  bmask;

	assign cw     = hct_pkg::ucode(pc_q);
	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (pc_q == hct_pkg::STEP_IDLE);
	assign go     = !(cw.emit && ov_q && !rpt.ready);

	// zero extent acts as one
	assign dx = (width_q == 16'd0) ? 16'd1 : width_q;
	assign dy = (height_q == 16'd0) ? 16'd1 : height_q;

	assign tx  = {remx_q, lox_q[15]};
	assign ty  = {remy_q, loy_q[15]};
	assign gex = tx >= {1'b0, dx};
	assign gey = ty >= {1'b0, dy};

	assign bmask = (act_q <= hct_pkg::ACT_LEFT_CLICK) ? 2'b01 : 2'b10;

	always_comb begin
		mod_d  = mod_q;
		held_d = held_q;
		btn_d  = btn_q;
		unique case (cw.op)
			hct_pkg::OP_MOD_SET:   mod_d  = mod_q | hct_pkg::mod_mask(code_q);
			hct_pkg::OP_MOD_CLR:   mod_d  = mod_q & ~hct_pkg::mod_mask(code_q);
			hct_pkg::OP_HELD_LOAD: held_d = hct_pkg::usage_of(code_q);
			hct_pkg::OP_HELD_CLR:  held_d = 8'd0;
			hct_pkg::OP_BTN_SET:   btn_d  = btn_q | bmask;
			hct_pkg::OP_BTN_CLR:   btn_d  = btn_q & ~bmask;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= hct_pkg::WIDTH_RESET;
			height_q <= hct_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == hct_pkg::CFG_WIDTH) width_q <= cfg_data;
			if (cfg_index == hct_pkg::CFG_HEIGHT) height_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= hct_pkg::STEP_IDLE;
			cnt_q  <= 4'd0;
			btn_q  <= 2'd0;
			mod_q  <= 3'd0;
			held_q <= 8'd0;
			ov_q   <= 1'b0;
		end else begin
			if (go) begin
				btn_q  <= btn_d;
				mod_q  <= mod_d;
				held_q <= held_d;
				unique case (cw.seq)
					hct_pkg::SEQ_WAIT: if (accept) pc_q <= hct_pkg::dispatch(cmd.action, cmd.key_code);
					hct_pkg::SEQ_NEXT: pc_q <= hct_pkg::PC_W'(pc_q + 1'b1);
					hct_pkg::SEQ_LOOP: if (cnt_q == 4'd0) pc_q <= hct_pkg::PC_W'(pc_q + 1'b1);
					hct_pkg::SEQ_END:  pc_q <= hct_pkg::STEP_IDLE;
				endcase
				if (cw.op == hct_pkg::OP_DIV_INIT) cnt_q <= 4'd15;
				else if (cw.op == hct_pkg::OP_DIV_STEP && cnt_q != 4'd0) cnt_q <= cnt_q - 4'd1;
			end
			if (go && cw.emit) ov_q <= 1'b1;
			else if (rpt.ready) ov_q <= 1'b0;
		end
	end

	// command word and move datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= cmd.action;
			code_q <= cmd.key_code;
			px_q   <= cmd.pos_x;
			py_q   <= cmd.pos_y;
		end
		unique case (cw.op)
			hct_pkg::OP_MUL: begin
				prodx_q <= 32'(px_q) * 32'(hct_pkg::SCALE_MAX);
				prody_q <= 32'(py_q) * 32'(hct_pkg::SCALE_MAX);
			end
			hct_pkg::OP_DIV_INIT: begin
				// quotient overflows 16 bits when the top half already reaches the divisor
				satx_q <= prodx_q[31:16] >= dx;
				saty_q <= prody_q[31:16] >= dy;
				remx_q <= prodx_q[31:16];
				remy_q <= prody_q[31:16];
				lox_q  <= prodx_q[15:0];
				loy_q  <= prody_q[15:0];
			end
			hct_pkg::OP_DIV_STEP: begin
				remx_q <= gex ? 16'(tx - {1'b0, dx}) : tx[15:0];
				remy_q <= gey ? 16'(ty - {1'b0, dy}) : ty[15:0];
				lox_q  <= {lox_q[14:0], gex};
				loy_q  <= {loy_q[14:0], gey};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (go && cw.emit) begin
			rpt.report_kind <= cw.kind;
			rpt.last        <= cw.last;
			rpt.buttons     <= (cw.kind == hct_pkg::KIND_BTN) ? btn_d : 2'd0;
			rpt.modifiers   <= (cw.kind == hct_pkg::KIND_KEY) ? mod_d : 3'd0;
			rpt.key_usage   <= (cw.kind == hct_pkg::KIND_KEY) ? held_d : 8'd0;
			if (cw.kind == hct_pkg::KIND_MOVE) begin
				rpt.abs_x <= satx_q ? 16'hFFFF : lox_q;
				rpt.abs_y <= saty_q ? 16'hFFFF : loy_q;
			end else begin
				rpt.abs_x <= 16'd0;
				rpt.abs_y <= 16'd0;
			end
		end
	end

	assign rpt.valid = ov_q;

	a_btn_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && rpt.report_kind == hct_pkg::KIND_BTN
		|-> rpt.modifiers == 3'd0 && rpt.key_usage == 8'd0 && rpt.abs_x == 16'd0)
		else $error("button report carries foreign fields");

	a_cnt_loop: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 4'd0 |-> pc_q == hct_pkg::STEP_DIV_LOOP)
		else $error("divider count live outside divide loop");

	a_move_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.action == hct_pkg::ACT_MOVE |=> pc_q == hct_pkg::STEP_MUL)
		else $error("move command not dispatched to multiply");

	a_first_half: assert property (@(posedge clk) disable iff (!arst_n)
		rpt.valid && !rpt.last |-> rpt.report_kind != hct_pkg::KIND_MOVE)
		else $error("move report without last");

endmodule

`default_nettype wire

// ----- tb/sv/hid_command_to_report_translator_core_tb.sv -----
`timescale 1ns / 1ps

module hid_command_to_report_translator_core_tb;

	typedef struct packed {
		logic [3:0]  action;
		logic [7:0]  key_code;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
	} command_t;

	typedef struct packed {
		logic [1:0]  report_kind;
		logic [1:0]  buttons;
		logic [15:0] abs_x;
		logic [15:0] abs_y;
		logic [2:0]  modifiers;
		logic [7:0]  key_usage;
		logic        last;
	} hid_report_t;

	class hid_report_predictor;
		hid_report_t expected_reports[$];
		logic [1:0]  button_bits;
		logic [2:0]  modifier_bits;
		logic [7:0]  held_usage;
		logic [15:0] screen_width;
		logic [15:0] screen_height;
		int          failures;

		function new();
			button_bits = '0;
			modifier_bits = '0;
			held_usage = '0;
			screen_width = hct_pkg::WIDTH_RESET;
			screen_height = hct_pkg::HEIGHT_RESET;
			failures = 0;
		endfunction

		function logic [7:0] key_usage_of(input logic [7:0] c);
			if (c >= 8'h41 && c <= 8'h5A) return 8'h04 + (c - 8'h41);
			if (c >= 8'h31 && c <= 8'h39) return 8'h1e + (c - 8'h31);
			if (c == 8'h30) return 8'h27;
			if (c >= 8'h70 && c <= 8'h7B) return 8'h3a + (c - 8'h70);
			if (c >= 8'h7C && c <= 8'h87) return 8'h68 + (c - 8'h7C);
			case (c)
				8'd91: return 8'h2f;
				8'd92: return 8'h31;
				8'd93: return 8'h30;
				8'd45: return 8'h2d;
				8'd43: return 8'h2e;
				8'd44: return 8'h36;
				8'd46: return 8'h37;
				8'd47: return 8'h38;
				8'd13: return 8'h28;
				8'd27: return 8'h29;
				8'd32: return 8'h2c;
				8'd9:  return 8'h2b;
				default: return 8'h00;
			endcase
		endfunction

		// floor(pos * SCALE_MAX / extent), zero extent behaves as one
		function logic [15:0] scale_position(input logic [15:0] pos, input logic [15:0] extent);
			logic [31:0] prod;
			logic [31:0] quo;
			logic [31:0] ext;
			ext = (extent == 16'd0) ? 32'd1 : {16'd0, extent};
			prod = {16'd0, pos} * {16'd0, hct_pkg::SCALE_MAX};
			quo = prod / ext;
			return (quo > 32'd65535) ? 16'hFFFF : quo[15:0];
		endfunction

		function void push_report(input logic [1:0] kind, input logic [15:0] x,
			input logic [15:0] y, input logic last);
			hid_report_t r;
			r = '0;
			r.report_kind = kind;
			r.last = last;
			if (kind == hct_pkg::KIND_BTN) r.buttons = button_bits;
			if (kind == hct_pkg::KIND_KEY) begin
				r.modifiers = modifier_bits;
				r.key_usage = held_usage;
			end
			if (kind == hct_pkg::KIND_MOVE) begin
				r.abs_x = x;
				r.abs_y = y;
			end
			expected_reports.push_back(r);
		endfunction

		// returns how many report words the command causes
		function int note_command(input command_t c);
			logic [2:0] mod_sel;
			logic [1:0] btn_sel;
			if (c.action <= hct_pkg::ACT_KEY_CLICK) begin
				if (c.key_code == hct_pkg::VK_SHIFT || c.key_code == hct_pkg::VK_CTRL ||
					c.key_code == hct_pkg::VK_ALT) begin
					mod_sel = (c.key_code == hct_pkg::VK_CTRL) ? 3'b001 :
						(c.key_code == hct_pkg::VK_SHIFT) ? 3'b010 : 3'b100;
					// click on a modifier key does nothing
					if (c.action == hct_pkg::ACT_KEY_CLICK) return 0;
					if (c.action == hct_pkg::ACT_KEY_DOWN) modifier_bits = modifier_bits | mod_sel;
					else modifier_bits = modifier_bits & ~mod_sel;
					push_report(hct_pkg::KIND_KEY, '0, '0, 1'b1);
					return 1;
				end
				if (c.action == hct_pkg::ACT_KEY_UP) begin
					held_usage = '0;
					push_report(hct_pkg::KIND_KEY, '0, '0, 1'b1);
					return 1;
				end
				held_usage = key_usage_of(c.key_code);
				if (c.action == hct_pkg::ACT_KEY_DOWN) begin
					push_report(hct_pkg::KIND_KEY, '0, '0, 1'b1);
					return 1;
				end
				push_report(hct_pkg::KIND_KEY, '0, '0, 1'b0);
				held_usage = '0;
				push_report(hct_pkg::KIND_KEY, '0, '0, 1'b1);
				return 2;
			end
			if (c.action <= hct_pkg::ACT_RGT_CLICK) begin
				btn_sel = (c.action <= hct_pkg::ACT_LEFT_CLICK) ? 2'b01 : 2'b10;
				case (c.action)
					hct_pkg::ACT_LEFT_UP, hct_pkg::ACT_RGT_UP: begin
						button_bits = button_bits & ~btn_sel;
						push_report(hct_pkg::KIND_BTN, '0, '0, 1'b1);
						return 1;
					end
					hct_pkg::ACT_LEFT_DOWN, hct_pkg::ACT_RGT_DOWN: begin
						button_bits = button_bits | btn_sel;
						push_report(hct_pkg::KIND_BTN, '0, '0, 1'b1);
						return 1;
					end
					default: begin
						button_bits = button_bits | btn_sel;
						push_report(hct_pkg::KIND_BTN, '0, '0, 1'b0);
						button_bits = button_bits & ~btn_sel;
						push_report(hct_pkg::KIND_BTN, '0, '0, 1'b1);
						return 2;
					end
				endcase
			end
			if (c.action == hct_pkg::ACT_MOVE) begin
				push_report(hct_pkg::KIND_MOVE, scale_position(c.pos_x, screen_width),
					scale_position(c.pos_y, screen_height), 1'b1);
				return 1;
			end
			return 0;
		endfunction

		function void compare_field(input string name, input int unsigned want,
			input int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_report(input hid_report_t r);
			hid_report_t want;
			if (expected_reports.size() == 0) begin
				$error("report word with nothing expected: kind %0d", r.report_kind);
				failures++;
				return;
			end
			want = expected_reports.pop_front();
			compare_field("report_kind", want.report_kind, r.report_kind);
			compare_field("buttons", want.buttons, r.buttons);
			compare_field("abs_x", want.abs_x, r.abs_x);
			compare_field("abs_y", want.abs_y, r.abs_y);
			compare_field("modifiers", want.modifiers, r.modifiers);
			compare_field("key_usage", want.key_usage, r.key_usage);
			compare_field("last", want.last, r.last);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request = 1'b0;
	int hold_left = 0;

	hid_report_predictor predictor = new();

	hct_cmd_if cmd ();
	hct_rpt_if rpt ();

	hid_command_to_report_translator_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rpt       (rpt),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// report side backpressure, with a single long hold-off when requested
	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 500;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rpt.ready <= 1'b0;
		end else begin
			rpt.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		hid_report_t r;
		if (arst_n && rpt.valid && rpt.ready) begin
			r.report_kind = rpt.report_kind;
			r.buttons = rpt.buttons;
			r.abs_x = rpt.abs_x;
			r.abs_y = rpt.abs_y;
			r.modifiers = rpt.modifiers;
			r.key_usage = rpt.key_usage;
			r.last = rpt.last;
			predictor.check_report(r);
		end
	end

	function automatic command_t make_command(input logic [3:0] act, input logic [7:0] code,
		input logic [15:0] x, input logic [15:0] y);
		command_t c;
		c.action = act;
		c.key_code = code;
		c.pos_x = x;
		c.pos_y = y;
		return c;
	endfunction

	function automatic logic [15:0] random_position(input logic [15:0] extent);
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, extent));
			1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic command_t random_command();
		command_t c;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 36)
			c.action = 4'($urandom_range(hct_pkg::ACT_KEY_DOWN, hct_pkg::ACT_KEY_CLICK));
		else if (pick < 66)
			c.action = 4'($urandom_range(hct_pkg::ACT_LEFT_DOWN, hct_pkg::ACT_RGT_CLICK));
		else if (pick < 92) c.action = hct_pkg::ACT_MOVE;
		else c.action = 4'($urandom_range(hct_pkg::ACT_MOVE + 1, 4'hF));
		case ($urandom_range(0, 3))
			0: c.key_code = 8'($urandom_range(hct_pkg::VK_SHIFT, hct_pkg::VK_ALT));
			1: c.key_code = 8'($urandom_range(8'h30, 8'h87));
			default: c.key_code = 8'($urandom_range(0, 255));
		endcase
		c.pos_x = random_position(predictor.screen_width);
		c.pos_y = random_position(predictor.screen_height);
		return c;
	endfunction

	task automatic send_command(input command_t c, output int produced);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.action <= c.action;
		cmd.key_code <= c.key_code;
		cmd.pos_x <= c.pos_x;
		cmd.pos_y <= c.pos_y;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		produced = predictor.note_command(c);
	endtask

	task automatic run_random(input int n);
		int done;
		int produced;
		done = 0;
		while (done < n) begin
			send_command(random_command(), produced);
			done++;
		end
	endtask

	task automatic wait_reports_drained();
		cmd.valid <= 1'b0;
		while (predictor.expected_reports.size() != 0) @(posedge clk);
		// a command with no report may still be in its move loop
		repeat (40) @(posedge clk);
	endtask

	task automatic set_extent(input logic [15:0] w, input logic [15:0] h);
		cfg_we <= 1'b1;
		cfg_index <= hct_pkg::CFG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= hct_pkg::CFG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		predictor.screen_width = w;
		predictor.screen_height = h;
	endtask

	initial begin
		#3_000_000;
		$display("hid_command_to_report_translator_core_tb: FAIL");
		$finish;
	end

	initial begin
		command_t directed[$];
		int produced;
		arst_n <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.action <= hct_pkg::ACT_KEY_DOWN;
		cmd.key_code <= '0;
		cmd.pos_x <= '0;
		cmd.pos_y <= '0;
		cfg_we <= 1'b0;
		cfg_index <= hct_pkg::CFG_WIDTH;
		cfg_data <= '0;
		tx_idle_pct = 10;
		rx_idle_pct = 71;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'h41, 16'h0000, 16'hFFFF)); // 'A'
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'h5A, 16'hFFFF, 16'h0000)); // 'Z'
		directed.push_back(make_command(hct_pkg::ACT_KEY_UP, 8'h41, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_KEY_CLICK, 8'h30, 16'h0000, 16'h0000)); // '0'
		directed.push_back(make_command(hct_pkg::ACT_KEY_CLICK, 8'h31, 16'h0000, 16'h0000)); // '1'
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'h39, 16'h0000, 16'h0000)); // '9'
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'h70, 16'h0000, 16'h0000)); // F1
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'h87, 16'h0000, 16'h0000)); // F24
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, 8'hFF, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, hct_pkg::VK_SHIFT, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, hct_pkg::VK_CTRL, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_DOWN, hct_pkg::VK_ALT, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_CLICK, 8'd9, 16'h0000, 16'h0000)); // tab
		directed.push_back(make_command(hct_pkg::ACT_KEY_CLICK, hct_pkg::VK_CTRL, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_UP, hct_pkg::VK_SHIFT, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_UP, hct_pkg::VK_CTRL, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_KEY_UP, hct_pkg::VK_ALT, 16'h0, 16'h0));
		directed.push_back(make_command(hct_pkg::ACT_LEFT_DOWN, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_RGT_DOWN, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_LEFT_UP, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_RGT_CLICK, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_LEFT_CLICK, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_MOVE, 8'h00, 16'h0000, 16'h0000));
		directed.push_back(make_command(hct_pkg::ACT_MOVE, 8'h00, 16'hFFFF, 16'hFFFF));
		directed.push_back(make_command(hct_pkg::ACT_MOVE, 8'h00, 16'd1919, 16'd1079));
		directed.push_back(make_command(4'(hct_pkg::ACT_MOVE + 1), 8'h41, 16'h0000, 16'h0000));
		directed.push_back(make_command(4'hF, 8'hFF, 16'hFFFF, 16'hFFFF));
		foreach (directed[i]) send_command(directed[i], produced);
		wait_reports_drained();

		set_extent(16'd1, 16'hFFFF);
		run_random(385);
		wait_reports_drained();

		tx_idle_pct = 71;
		rx_idle_pct = 10;
		set_extent(16'hFFFF, 16'd1);
		run_random(385);
		wait_reports_drained();

		// zero extent acts as one
		set_extent(16'd0, 16'($urandom_range(1, 65535)));
		run_random(385);
		wait_reports_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_extent(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		hold_request = 1'b1;
		run_random(385);
		wait_reports_drained();

		set_extent(16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
		run_random(385);
		wait_reports_drained();

		if (predictor.failures == 0 && predictor.expected_reports.size() == 0) begin
			$display("hid_command_to_report_translator_core_tb: PASS");
		end else begin
			$display("hid_command_to_report_translator_core_tb: FAIL");
		end
		$finish;
	end

endmodule
